// File: design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and character constants for the percent decoder.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [3:0] HEX_ALPHA     = 4'd10;
	localparam int unsigned MAX_OUT      = 3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [7:0]            held;
		logic [1:0]            cnt;
		logic [2:0][7:0]       bytes;
		logic [2:0]            lasts;
	} dec_t;

endpackage

// File: design/pcd_decode.sv
// ----------------------------------------------------------------------------
// pcd_decode
// Combinational decode of one byte against the escape state; yields the next
// state and up to three output bytes with their last flags.
// ----------------------------------------------------------------------------
module pcd_decode (
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  pcd_pkg::phase_t phase,
	input  logic [7:0]      held,
	output pcd_pkg::dec_t   dec
);
	import pcd_pkg::*;

	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, HEX_ALPHA + {1'b0, b[2:0]} - 4'd1};
		end
		return r;
	endfunction

	logic [4:0] nib_b;
	logic [4:0] nib_h;

	assign nib_b = nibble_of(in_byte);
	assign nib_h = nibble_of(held);

	always_comb begin
		logic       fresh;
		logic [1:0] n;
		dec.phase = PH_IDLE;
		dec.held  = held;
		dec.bytes = '0;
		dec.lasts = '0;
		fresh     = 1'b0;
		n         = 2'd0;
		case (phase)
			PH_PCT: begin
				if (nib_b[4]) begin
					dec.held  = in_byte;
					dec.phase = PH_HEX;
				end else begin
					dec.bytes[n] = CH_PERCENT;
					n            = n + 2'd1;
					fresh        = 1'b1;
				end
			end
			PH_HEX: begin
				if (nib_b[4] && nib_h[4]) begin
					dec.bytes[n] = {nib_h[3:0], nib_b[3:0]};
					n            = n + 2'd1;
				end else begin
					dec.bytes[n] = CH_PERCENT;
					n            = n + 2'd1;
					dec.bytes[n] = held;
					n            = n + 2'd1;
					fresh        = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (in_byte == CH_PERCENT) begin
				dec.phase = PH_PCT;
			end else if (in_byte == CH_UNDERSCORE) begin
				dec.bytes[n] = CH_SPACE;
				n            = n + 2'd1;
			end else begin
				dec.bytes[n] = in_byte;
				n            = n + 2'd1;
			end
		end
		if (in_last) begin
			if (dec.phase == PH_PCT) begin
				dec.bytes[n] = CH_PERCENT;
				n            = n + 2'd1;
			end else if (dec.phase == PH_HEX) begin
				dec.bytes[n] = CH_PERCENT;
				n            = n + 2'd1;
				dec.bytes[n] = dec.held;
				n            = n + 2'd1;
			end
			dec.phase = PH_IDLE;
			if (n != 2'd0) begin
				dec.lasts[n - 2'd1] = 1'b1;
			end
		end
		dec.cnt = n;
	end

endmodule

// File: design/percent_decoder.sv
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming URL percent decoder: %hh becomes one byte, underscore becomes a
// space, broken escapes pass through literally.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   s_*      in         tdata[7:0] in_byte, tlast in_last
//   m_*      out        tdata[7:0] out_byte, tlast out_last
//
// one input byte is decoded per cycle while s_tready is high, straight into a
// three-entry result register; results then leave on the output in order.
// inputs producing zero or one result sustain one byte per cycle; a broken
// escape producing two or three results holds s_tready low while they drain.
// arst_n clears the escape state and empties the result register.
// m_tready low stalls the result register and, while it holds any result,
// the input side as well.
module percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);
	import pcd_pkg::*;

	phase_t          phase_q;
	logic [7:0]      held_q;
	logic [1:0]      cnt_q;
	logic [2:0][7:0] byte_q;
	logic [2:0]      last_q;
	dec_t            dec;
	logic            s_acc;
	logic            m_acc;

	pcd_decode u_decode (
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.phase   (phase_q),
		.held    (held_q),
		.dec     (dec)
	);

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = byte_q[0];
	assign m_tlast  = last_q[0];
	assign m_acc    = m_tvalid && m_tready;
	assign s_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
			cnt_q   <= 2'd0;
		end else if (s_acc) begin
			phase_q <= dec.phase;
			held_q  <= dec.held;
			cnt_q   <= dec.cnt;
		end else if (m_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_q <= dec.bytes;
			last_q <= dec.lasts;
		end else if (m_acc) begin
			byte_q <= {8'd0, byte_q[2], byte_q[1]};
			last_q <= {1'b0, last_q[2], last_q[1]};
		end
	end

endmodule

// File: design/pcd_check.sv
// ----------------------------------------------------------------------------
// pcd_check
// Port-level checks for the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcd_check (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped during stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("m payload changed during stall");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no pending result");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("last input produced no result");

endmodule

bind percent_decoder pcd_check u_pcd_check (.*);

// File: tb/tb_percent_decoder.sv
// ----------------------------------------------------------------------------
// tb_percent_decoder
// Drives encoded strings into the percent decoder: hand-picked escapes first,
// then random strings built from valid escapes, broken escapes, underscores
// and plain bytes. A scoreboard decodes every accepted item on its own and
// checks each output item in order. Both sides idle at random outside a steady
// run; the receiver also holds off for a long stretch so the input side stalls.
// ----------------------------------------------------------------------------
module tb_percent_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import pcd_pkg::*;

	localparam int unsigned STRING_ITEMS = 430;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned HOLD_CYCLES  = 150;

	class decode_scoreboard;
		typedef struct {
			logic [7:0] data;
			logic       eos;
		} dec_item_t;

		phase_t     phase;
		logic [7:0] held;
		dec_item_t  decoded_q[$];
		int         errors;
		int         reported;

		function new();
			phase    = PH_IDLE;
			held     = '0;
			errors   = 0;
			reported = 0;
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39)
				return int'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66)
				return int'(HEX_ALPHA) + int'(c - 8'h61);
			if (c >= 8'h41 && c <= 8'h46)
				return int'(HEX_ALPHA) + int'(c - 8'h41);
			return -1;
		endfunction

		function void push_byte(logic [7:0] d);
			dec_item_t it;
			it.data = d;
			it.eos  = 1'b0;
			decoded_q = {decoded_q, it};
		endfunction

		// byte seen with no escape pending
		function void take_plain(logic [7:0] c);
			if (c == CH_PERCENT)
				phase = PH_PCT;
			else if (c == CH_UNDERSCORE)
				push_byte(CH_SPACE);
			else
				push_byte(c);
		endfunction

		function void note_input(logic [7:0] c, logic eos);
			int         start;
			int         hi;
			int         lo;
			logic [7:0] v;
			start = decoded_q.size();
			case (phase)
				PH_PCT: begin
					if (hex_value(c) >= 0) begin
						held  = c;
						phase = PH_HEX;
					end else begin
						phase = PH_IDLE;
						push_byte(CH_PERCENT);
						take_plain(c);
					end
				end
				PH_HEX: begin
					hi    = hex_value(held);
					lo    = hex_value(c);
					phase = PH_IDLE;
					if (hi >= 0 && lo >= 0) begin
						v = {hi[3:0], lo[3:0]};
						push_byte(v);
					end else begin
						push_byte(CH_PERCENT);
						push_byte(held);
						take_plain(c);
					end
				end
				default: begin
					phase = PH_IDLE;
					take_plain(c);
				end
			endcase
			if (eos) begin
				// flush a truncated escape
				if (phase == PH_PCT) begin
					push_byte(CH_PERCENT);
				end else if (phase == PH_HEX) begin
					push_byte(CH_PERCENT);
					push_byte(held);
				end
				phase = PH_IDLE;
				if (decoded_q.size() > start)
					decoded_q[decoded_q.size() - 1].eos = 1'b1;
			end
		endfunction

		function void check_result(logic [7:0] d, logic eos);
			dec_item_t want;
			if (decoded_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected output item: data %02h last %0b", d, eos);
				end
				return;
			end
			want = decoded_q.pop_front();
			if (want.data !== d || want.eos !== eos) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: expected data %02h last %0b, got data %02h last %0b",
						want.data, want.eos, d, eos);
				end
			end
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;   // [7:0] in_byte
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [7:0] out_byte
	logic       m_tlast;

	decode_scoreboard sb = new();

	bit steady   = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int unsigned cycles = 0;

	percent_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_percent_decoder: done, errors");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 11);
			end
		end
	end

	task automatic send(input logic [7:0] c, input logic eos);
		if (!steady && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'h30 + 8'(v);
		if (v < 16)
			return 8'h61 + 8'(v - 10);
		return 8'h41 + 8'(v - 16);
	endfunction

	task automatic send_random_string();
		logic [7:0] chars[$];
		int         pieces;
		int         i;
		pieces = $urandom_range(1, 5);
		for (i = 0; i < pieces; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: chars = {chars, CH_PERCENT, rand_hex(), rand_hex()};
				3: chars = {chars, CH_UNDERSCORE};
				4, 5: chars = {chars, 8'($urandom_range(0, 255))};
				6: chars = {chars, 8'($urandom_range(8'h61, 8'h7A))};
				7: chars = {chars, CH_PERCENT, 8'($urandom_range(0, 255))};
				8: chars = {chars, CH_PERCENT, rand_hex(), 8'($urandom_range(0, 255))};
				default: chars = {chars, CH_PERCENT};
			endcase
		end
		for (i = 0; i < chars.size(); i++)
			send(chars[i], i == chars.size() - 1);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, underscore, both hex cases, decoded percent stays literal
		send(8'h00, 1'b0);
		send(8'hFF, 1'b1);
		send(CH_UNDERSCORE, 1'b1);
		send(CH_PERCENT, 1'b0);
		send("a", 1'b0);
		send("F", 1'b0);
		send(CH_PERCENT, 1'b0);
		send("2", 1'b0);
		send("5", 1'b1);
		// bad first digit that opens a new escape
		send(CH_PERCENT, 1'b0);
		send(CH_PERCENT, 1'b0);
		send("3", 1'b0);
		send("f", 1'b1);
		// bad second digit, then a new escape broken by a non-hex byte
		send(CH_PERCENT, 1'b0);
		send("7", 1'b0);
		send(CH_UNDERSCORE, 1'b0);
		send(CH_PERCENT, 1'b0);
		send("1", 1'b0);
		send(CH_PERCENT, 1'b0);
		send("G", 1'b1);
		// truncated escapes at end of string
		send(CH_PERCENT, 1'b1);
		send(CH_PERCENT, 1'b0);
		send("9", 1'b1);

		while (items_sent < 140) send_random_string();
		hold_req = 1'b1;
		while (items_sent < 200) send_random_string();
		wait_drained();
		steady = 1'b1;
		while (items_sent < 300) send_random_string();
		steady = 1'b0;
		while (items_sent < STRING_ITEMS) send_random_string();

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_percent_decoder: done, clean");
		else
			$display("tb_percent_decoder: done, errors");
		$finish;
	end

endmodule
